>>> hdl/csq_pkg.sv
`default_nettype none

package csq_pkg;

  localparam int MAX_WAITERS_DEF = 16;
  localparam int ID_BITS_DEF     = 8;

  localparam int KIND_W   = 2;
  localparam int TID_W    = 8;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 16;
  localparam int INIT_W   = 15;
  localparam int WOKEN_W  = 8;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sd32768;

  typedef enum logic [KIND_W-1:0] {
    KIND_WAIT   = 2'd0,
    KIND_TRY    = 2'd1,
    KIND_SIGNAL = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED     = 4'd0,
    ST_BLOCKED     = 4'd1,
    ST_TRY_OK      = 4'd2,
    ST_TRY_REFUSED = 4'd3,
    ST_SIG_NONE    = 4'd4,
    ST_SIG_WOKE    = 4'd5,
    ST_CAN_REMOVED = 4'd6,
    ST_CAN_MISSING = 4'd7,
    ST_SATURATED   = 4'd8,
    ST_QUEUE_FULL  = 4'd9
  } status_t;

  // queue update request from the decision logic
  typedef struct packed {
    logic push;
    logic drop_head;
    logic drop_match;
  } q_cmd_t;

  // queue status seen by the decision logic
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
  } q_stat_t;

endpackage

`default_nettype wire

>>> hdl/csq_wait_queue.sv
`default_nettype none

module csq_wait_queue #(
  parameter int MAX_WAITERS = csq_pkg::MAX_WAITERS_DEF,
  parameter int ID_BITS     = csq_pkg::ID_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire csq_pkg::q_cmd_t    cmd,
  input  wire logic [ID_BITS-1:0] tid,
  output csq_pkg::q_stat_t        stat,
  output logic [ID_BITS-1:0]      head
);

  localparam int POS_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int TOT_W = $clog2(MAX_WAITERS + 1);

  logic [ID_BITS-1:0]   ids_r [MAX_WAITERS];
  logic [TOT_W-1:0]     total_r;
  logic [TOT_W-1:0]     total_nxt;
  logic [MAX_WAITERS-1:0] hit;
  logic [POS_W-1:0]     match_pos;
  logic [POS_W-1:0]     rm_pos;
  logic                 do_push;
  logic                 do_drop;

  // parallel compare against the live entries, oldest match wins
  always_comb begin
    match_pos = '0;
    for (int j = 0; j < MAX_WAITERS; j++) begin
      hit[j] = (TOT_W'(j) < total_r) && (ids_r[j] == tid);
    end
    for (int j = MAX_WAITERS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        match_pos = POS_W'(j);
      end
    end
  end

  assign stat.empty = (total_r == '0);
  assign stat.full  = (total_r == TOT_W'(MAX_WAITERS));
  assign stat.found = |hit;
  assign head       = ids_r[0];

  assign do_push = upd && cmd.push;
  assign do_drop = upd && (cmd.drop_head || cmd.drop_match);
  assign rm_pos  = cmd.drop_match ? match_pos : '0;

  always_comb begin
    total_nxt = total_r;
    if (do_push) begin
      total_nxt = total_r + TOT_W'(1);
    end else if (do_drop) begin
      total_nxt = total_r - TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_entry
    if (g < MAX_WAITERS - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (do_drop && (POS_W'(g) >= rm_pos)) begin
          ids_r[g] <= ids_r[g+1];
        end else if (do_push && (total_r == TOT_W'(g))) begin
          ids_r[g] <= tid;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (do_push && (total_r == TOT_W'(g))) begin
          ids_r[g] <= tid;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_WAITERS))
    else $error("waiter total beyond queue depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && cmd.push) |-> !stat.full)
    else $error("push into full queue");
`endif

endmodule

`default_nettype wire

>>> hdl/csq_decide.sv
`default_nettype none

module csq_decide (
  input  wire csq_pkg::kind_t                     kind,
  input  wire logic signed [csq_pkg::COUNT_W-1:0] count,
  input  wire csq_pkg::q_stat_t                   qstat,
  output csq_pkg::status_t                        status,
  output logic signed [csq_pkg::COUNT_W-1:0]      count_nxt,
  output csq_pkg::q_cmd_t                         qcmd
);

  always_comb begin
    status    = csq_pkg::ST_GRANTED;
    count_nxt = count;
    qcmd      = '0;
    unique case (kind)
      csq_pkg::KIND_WAIT: begin
        if (count == csq_pkg::COUNT_MIN) begin
          status = csq_pkg::ST_SATURATED;
        end else if (count <= 0) begin
          if (qstat.full) begin
            status = csq_pkg::ST_QUEUE_FULL;
          end else begin
            count_nxt = count - 16'sd1;
            qcmd.push = 1'b1;
            status    = csq_pkg::ST_BLOCKED;
          end
        end else begin
          count_nxt = count - 16'sd1;
          status    = csq_pkg::ST_GRANTED;
        end
      end
      csq_pkg::KIND_TRY: begin
        if (count > 0) begin
          count_nxt = count - 16'sd1;
          status    = csq_pkg::ST_TRY_OK;
        end else begin
          status = csq_pkg::ST_TRY_REFUSED;
        end
      end
      csq_pkg::KIND_SIGNAL: begin
        if (count == csq_pkg::COUNT_MAX) begin
          status = csq_pkg::ST_SATURATED;
        end else begin
          count_nxt = count + 16'sd1;
          if ((count < 0) && !qstat.empty) begin
            qcmd.drop_head = 1'b1;
            status         = csq_pkg::ST_SIG_WOKE;
          end else begin
            status = csq_pkg::ST_SIG_NONE;
          end
        end
      end
      csq_pkg::KIND_CANCEL: begin
        if (!qstat.found) begin
          status = csq_pkg::ST_CAN_MISSING;
        end else if (count == csq_pkg::COUNT_MAX) begin
          status = csq_pkg::ST_SATURATED;
        end else begin
          count_nxt       = count + 16'sd1;
          qcmd.drop_match = 1'b1;
          status          = csq_pkg::ST_CAN_REMOVED;
        end
      end
      default: begin
        status = csq_pkg::ST_GRANTED;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/counting_semaphore_wait_queue_top.sv
// Counting semaphore with a FIFO queue of blocked thread ids.
// Requests enter on the in_ channel (in_kind, in_thread_id) with valid and
// stall; one result per request leaves on the out_ channel with status,
// woken id and the count after the request.
// A write on cfg_wr_en loads cfg_wr_data into the count; the queue is kept.
// A request accepted into the input register moves on to the result register
// once the result register is empty or its result is being taken.
// Throughput: one request per cycle while the receiver does not stall, set by
// the update of the count register and the shift queue with its parallel id compare.
// Reset clears the count, the queue fill and both valid flags; queue
// entries are not cleared and are only read below the fill level.
// When the receiver stalls, the result register holds and the input
// register fills; in_stall then rises until the result is taken.
`default_nettype none

module counting_semaphore_wait_queue_top #(
  parameter int MAX_WAITERS = csq_pkg::MAX_WAITERS_DEF,
  parameter int ID_BITS     = csq_pkg::ID_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [csq_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [csq_pkg::TID_W-1:0]      in_thread_id,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [csq_pkg::STATUS_W-1:0]        out_status,
  output logic [csq_pkg::WOKEN_W-1:0]         out_woken_id,
  output logic signed [csq_pkg::COUNT_W-1:0]  out_count_after,
  input  wire logic                           cfg_wr_en,
  input  wire logic [csq_pkg::INIT_W-1:0]     cfg_wr_data
);

  logic                                item_v_r;
  csq_pkg::kind_t                      kind_r;
  logic [ID_BITS-1:0]                  tid_r;
  logic signed [csq_pkg::COUNT_W-1:0]  count_r;
  logic signed [csq_pkg::COUNT_W-1:0]  count_nxt;
  logic                                adv;
  csq_pkg::status_t                    status;
  csq_pkg::q_cmd_t                     qcmd;
  csq_pkg::q_stat_t                    qstat;
  logic [ID_BITS-1:0]                  head;
  logic                                out_valid_r;
  csq_pkg::status_t                    out_status_r;
  logic [csq_pkg::WOKEN_W-1:0]         out_woken_r;
  logic signed [csq_pkg::COUNT_W-1:0]  out_count_r;

  assign adv      = item_v_r && (!out_valid_r || !out_stall);
  assign in_stall = item_v_r && out_valid_r && out_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (!in_stall) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= csq_pkg::kind_t'(in_kind);
      tid_r  <= ID_BITS'(in_thread_id);
    end
  end

  csq_decide u_decide (
    .kind      (kind_r),
    .count     (count_r),
    .qstat     (qstat),
    .status    (status),
    .count_nxt (count_nxt),
    .qcmd      (qcmd)
  );

  csq_wait_queue #(
    .MAX_WAITERS (MAX_WAITERS),
    .ID_BITS     (ID_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (adv),
    .cmd   (qcmd),
    .tid   (tid_r),
    .stat  (qstat),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= {1'b0, cfg_wr_data};
    end else if (adv) begin
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= item_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status;
      out_woken_r  <= qcmd.drop_head ? csq_pkg::WOKEN_W'(head) : '0;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_woken_id    = out_woken_r;
  assign out_count_after = out_count_r;

`ifndef SYNTHESIS
  a_blocked_negative: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == csq_pkg::ST_BLOCKED) |-> (out_count_r < 0))
    else $error("blocked item with non-negative count");

  a_woke_non_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == csq_pkg::ST_SIG_WOKE) |-> (out_count_r <= 0))
    else $error("waiter released with positive count");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (item_v_r && $stable(kind_r) && $stable(tid_r)))
    else $error("input register changed while stalled");
`endif

endmodule

`default_nettype wire
